/* rtl/closest_point_on_triangle_assert.svh */
// Assertion macros for the closest-point checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
// Implication: whenever ante holds, cons must hold in the same cycle.
`define CPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Invariant: cond holds at every sampled edge.
`define CPT_ASSERT_ALW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

/* rtl/cpt_pkg.sv */
// Shared widths, types and region codes for the closest-point pipeline.
// No dependencies; the modules and the testbench refer to it by scoped names.
`default_nettype none
package cpt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int DIFF_W  = COORD_WIDTH + 1;   // vertex/point difference
    localparam int PROD_W  = 2 * DIFF_W;        // one coordinate product
    localparam int DOT_W   = PROD_W + 2;        // sum of three products
    localparam int HALF_W  = DOT_W / 2;         // split for the cross products
    localparam int PP_W    = 2 * HALF_W + 1;    // signed partial product
    localparam int CROSS_W = 2 * DOT_W;         // full cross product
    localparam int NUM_W   = CROSS_W + 4;       // numerators and denominators
    localparam int WGT_W   = FRAC_BITS + 1;     // weight in [0, 1.0]
    localparam int EMIT_W  = WGT_W + DIFF_W + 2;

    // dot: 3, cross: 4, divider: 1 + FRAC_BITS, emit: 2
    localparam int LATENCY = FRAC_BITS + 10;
    localparam int WARM_W  = $clog2(LATENCY + 2);

    localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic [2:0][COORD_WIDTH-1:0] vec3_t;   // [0] x, [1] y, [2] z

    typedef struct packed {
        vec3_t a;
        vec3_t b;
        vec3_t c;
    } geom_t;

    typedef enum logic [2:0] {
        REG_V0  = 3'd0,
        REG_V1  = 3'd1,
        REG_E01 = 3'd2,
        REG_V2  = 3'd3,
        REG_E02 = 3'd4,
        REG_E12 = 3'd5,
        REG_IN  = 3'd6
    } region_t;

    // d1..d6 at indexes 0..5
    typedef logic [5:0][DOT_W-1:0] dots_t;

    typedef struct packed {
        logic [NUM_W-1:0] num0;
        logic [NUM_W-1:0] num1;
        logic [NUM_W-1:0] den;
        region_t          region;
        geom_t            geom;
    } div_req_t;

    typedef struct packed {
        logic    lo0;
        logic    hi0;
        logic    lo1;
        logic    hi1;
        region_t region;
        geom_t   geom;
    } div_side_t;

endpackage
`default_nettype wire

/* rtl/cpt_dot.sv */
// Stages 1-3: edge/point differences, coordinate products, six dot products.
// Depends on cpt_pkg.
`default_nettype none
module cpt_dot (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cpt_pkg::vec3_t point,
    input  cpt_pkg::geom_t geom_in,
    output logic           out_valid,
    output cpt_pkg::dots_t dots,
    output cpt_pkg::geom_t geom_out
);

    logic [2:0] valid_reg;

    logic [2:0][cpt_pkg::DIFF_W-1:0] ab_reg, ac_reg, ap_reg, bp_reg, cp_reg;
    logic [2:0][cpt_pkg::DIFF_W-1:0] ab_next, ac_next, ap_next, bp_next, cp_next;
    logic [5:0][2:0][cpt_pkg::PROD_W-1:0] prod_reg, prod_next;
    cpt_pkg::dots_t dots_reg, dots_next;
    cpt_pkg::geom_t geom1_reg, geom2_reg, geom3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ab_next[k] = cpt_pkg::DIFF_W'($signed(geom_in.b[k]))
                       - cpt_pkg::DIFF_W'($signed(geom_in.a[k]));
            ac_next[k] = cpt_pkg::DIFF_W'($signed(geom_in.c[k]))
                       - cpt_pkg::DIFF_W'($signed(geom_in.a[k]));
            ap_next[k] = cpt_pkg::DIFF_W'($signed(point[k]))
                       - cpt_pkg::DIFF_W'($signed(geom_in.a[k]));
            bp_next[k] = cpt_pkg::DIFF_W'($signed(point[k]))
                       - cpt_pkg::DIFF_W'($signed(geom_in.b[k]));
            cp_next[k] = cpt_pkg::DIFF_W'($signed(point[k]))
                       - cpt_pkg::DIFF_W'($signed(geom_in.c[k]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[0][k] = cpt_pkg::PROD_W'($signed(ab_reg[k]) * $signed(ap_reg[k]));
            prod_next[1][k] = cpt_pkg::PROD_W'($signed(ac_reg[k]) * $signed(ap_reg[k]));
            prod_next[2][k] = cpt_pkg::PROD_W'($signed(ab_reg[k]) * $signed(bp_reg[k]));
            prod_next[3][k] = cpt_pkg::PROD_W'($signed(ac_reg[k]) * $signed(bp_reg[k]));
            prod_next[4][k] = cpt_pkg::PROD_W'($signed(ab_reg[k]) * $signed(cp_reg[k]));
            prod_next[5][k] = cpt_pkg::PROD_W'($signed(ac_reg[k]) * $signed(cp_reg[k]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            dots_next[i] = cpt_pkg::DOT_W'($signed(prod_reg[i][0]))
                         + cpt_pkg::DOT_W'($signed(prod_reg[i][1]))
                         + cpt_pkg::DOT_W'($signed(prod_reg[i][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ab_reg    <= ab_next;
        ac_reg    <= ac_next;
        ap_reg    <= ap_next;
        bp_reg    <= bp_next;
        cp_reg    <= cp_next;
        geom1_reg <= geom_in;
        prod_reg  <= prod_next;
        geom2_reg <= geom1_reg;
        dots_reg  <= dots_next;
        geom3_reg <= geom2_reg;
    end

    assign out_valid = valid_reg[2];
    assign dots      = dots_reg;
    assign geom_out  = geom3_reg;

endmodule
`default_nettype wire

/* rtl/cpt_cross.sv */
// Stages 4-7: split cross products of dot terms, region tests, divider request.
// Depends on cpt_pkg.
`default_nettype none
module cpt_cross (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cpt_pkg::dots_t    dots,
    input  cpt_pkg::geom_t    geom_in,
    output logic              out_valid,
    output cpt_pkg::div_req_t req
);

    logic [3:0] valid_reg;

    // cross operands: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    logic [5:0][cpt_pkg::DOT_W-1:0] opa, opb;

    logic [5:0][cpt_pkg::PP_W-1:0]    hh_reg, hl_reg, lh_reg, hh_next, hl_next, lh_next;
    logic [5:0][cpt_pkg::DOT_W-1:0]   ll_reg, ll_next;
    logic [5:0][cpt_pkg::CROSS_W-1:0] prod_reg, prod_next;
    logic [cpt_pkg::NUM_W-1:0]        va_reg, vb_reg, vc_reg, va_next, vb_next, vc_next;
    cpt_pkg::dots_t    dots4_reg, dots5_reg, dots6_reg;
    cpt_pkg::geom_t    geom4_reg, geom5_reg, geom6_reg;
    cpt_pkg::div_req_t req_reg, req_next;

    always_comb
    begin
        opa[0] = dots[0]; opb[0] = dots[3];
        opa[1] = dots[2]; opb[1] = dots[1];
        opa[2] = dots[4]; opb[2] = dots[1];
        opa[3] = dots[0]; opb[3] = dots[5];
        opa[4] = dots[2]; opb[4] = dots[5];
        opa[5] = dots[4]; opb[5] = dots[3];
    end

    // signed high half times signed high half, mixed halves, unsigned lows
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            hh_next[i] = cpt_pkg::PP_W'(
                $signed(opa[i][cpt_pkg::DOT_W-1:cpt_pkg::HALF_W])
              * $signed(opb[i][cpt_pkg::DOT_W-1:cpt_pkg::HALF_W]));
            hl_next[i] = cpt_pkg::PP_W'(
                $signed(opa[i][cpt_pkg::DOT_W-1:cpt_pkg::HALF_W])
              * $signed({1'b0, opb[i][cpt_pkg::HALF_W-1:0]}));
            lh_next[i] = cpt_pkg::PP_W'(
                $signed({1'b0, opa[i][cpt_pkg::HALF_W-1:0]})
              * $signed(opb[i][cpt_pkg::DOT_W-1:cpt_pkg::HALF_W]));
            ll_next[i] = cpt_pkg::DOT_W'(opa[i][cpt_pkg::HALF_W-1:0]
                                       * opb[i][cpt_pkg::HALF_W-1:0]);
        end
    end

    always_comb
    begin
        logic signed [cpt_pkg::CROSS_W-1:0] w_hh;
        logic signed [cpt_pkg::CROSS_W-1:0] w_mid;
        logic signed [cpt_pkg::CROSS_W-1:0] w_ll;
        for (int i = 0; i < 6; i++)
        begin
            w_hh  = cpt_pkg::CROSS_W'($signed(hh_reg[i]));
            w_mid = cpt_pkg::CROSS_W'($signed(hl_reg[i]))
                  + cpt_pkg::CROSS_W'($signed(lh_reg[i]));
            w_ll  = cpt_pkg::CROSS_W'(ll_reg[i]);
            prod_next[i] = (w_hh <<< (2 * cpt_pkg::HALF_W))
                         + (w_mid <<< cpt_pkg::HALF_W) + w_ll;
        end
    end

    always_comb
    begin
        vc_next = cpt_pkg::NUM_W'($signed(prod_reg[0])) - cpt_pkg::NUM_W'($signed(prod_reg[1]));
        vb_next = cpt_pkg::NUM_W'($signed(prod_reg[2])) - cpt_pkg::NUM_W'($signed(prod_reg[3]));
        va_next = cpt_pkg::NUM_W'($signed(prod_reg[4])) - cpt_pkg::NUM_W'($signed(prod_reg[5]));
    end

    // Voronoi tests in priority order; a non-positive divisor falls back to vertex 0
    always_comb
    begin
        logic signed [cpt_pkg::NUM_W-1:0] d1, d2, d3, d4, d5, d6;
        logic signed [cpt_pkg::NUM_W-1:0] va, vb, vc, e1, e2;
        logic signed [cpt_pkg::NUM_W-1:0] den_e01, den_e02, den_e12, den_in;
        d1 = cpt_pkg::NUM_W'($signed(dots6_reg[0]));
        d2 = cpt_pkg::NUM_W'($signed(dots6_reg[1]));
        d3 = cpt_pkg::NUM_W'($signed(dots6_reg[2]));
        d4 = cpt_pkg::NUM_W'($signed(dots6_reg[3]));
        d5 = cpt_pkg::NUM_W'($signed(dots6_reg[4]));
        d6 = cpt_pkg::NUM_W'($signed(dots6_reg[5]));
        va = $signed(va_reg);
        vb = $signed(vb_reg);
        vc = $signed(vc_reg);
        e1 = d4 - d3;
        e2 = d5 - d6;
        den_e01 = d1 - d3;
        den_e02 = d2 - d6;
        den_e12 = e1 + e2;
        den_in  = va + vb + vc;

        req_next.num0   = '0;
        req_next.num1   = '0;
        req_next.den    = cpt_pkg::NUM_W'(1);
        req_next.region = cpt_pkg::REG_V0;
        req_next.geom   = geom6_reg;

        if (d1 <= 0 && d2 <= 0)
        begin
            req_next.region = cpt_pkg::REG_V0;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            req_next.region = cpt_pkg::REG_V1;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            if (den_e01 > 0)
            begin
                req_next.region = cpt_pkg::REG_E01;
                req_next.num0   = d1;
                req_next.den    = den_e01;
            end
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            req_next.region = cpt_pkg::REG_V2;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            if (den_e02 > 0)
            begin
                req_next.region = cpt_pkg::REG_E02;
                req_next.num1   = d2;
                req_next.den    = den_e02;
            end
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            if (den_e12 > 0)
            begin
                req_next.region = cpt_pkg::REG_E12;
                req_next.num0   = e1;
                req_next.den    = den_e12;
            end
        end
        else if (den_in > 0)
        begin
            req_next.region = cpt_pkg::REG_IN;
            req_next.num0   = vb;
            req_next.num1   = vc;
            req_next.den    = den_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        hh_reg    <= hh_next;
        hl_reg    <= hl_next;
        lh_reg    <= lh_next;
        ll_reg    <= ll_next;
        dots4_reg <= dots;
        geom4_reg <= geom_in;
        prod_reg  <= prod_next;
        dots5_reg <= dots4_reg;
        geom5_reg <= geom4_reg;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        vc_reg    <= vc_next;
        dots6_reg <= dots5_reg;
        geom6_reg <= geom5_reg;
        req_reg   <= req_next;
    end

    assign out_valid = valid_reg[3];
    assign req       = req_reg;

endmodule
`default_nettype wire

/* rtl/cpt_div.sv */
// Two-lane restoring divider over a shared positive divisor, one quotient bit per stage.
// Depends on cpt_pkg.
`default_nettype none
module cpt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  cpt_pkg::div_req_t            req,
    output logic                         out_valid,
    output logic [cpt_pkg::WGT_W-1:0]    wgt0,
    output logic [cpt_pkg::WGT_W-1:0]    wgt1,
    output cpt_pkg::region_t             region,
    output cpt_pkg::geom_t               geom_out
);

    logic [cpt_pkg::FRAC_BITS:0] valid_reg;

    logic [cpt_pkg::NUM_W-1:0]     rem0_reg  [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::NUM_W-1:0]     rem1_reg  [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::NUM_W-1:0]     den_reg   [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::FRAC_BITS-1:0] q0_reg    [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::FRAC_BITS-1:0] q1_reg    [cpt_pkg::FRAC_BITS+1];
    cpt_pkg::div_side_t            side_reg  [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::NUM_W-1:0]     rem0_next [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::NUM_W-1:0]     rem1_next [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::NUM_W-1:0]     den_next  [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::FRAC_BITS-1:0] q0_next   [cpt_pkg::FRAC_BITS+1];
    logic [cpt_pkg::FRAC_BITS-1:0] q1_next   [cpt_pkg::FRAC_BITS+1];
    cpt_pkg::div_side_t            side_next [cpt_pkg::FRAC_BITS+1];
    cpt_pkg::div_side_t            side_last;

    always_comb
    begin
        logic [cpt_pkg::NUM_W-1:0] t0, t1;
        logic                      g0, g1;

        // entry: clamp flags; a weight is 0 for num <= 0 and one for num >= den
        rem0_next[0] = req.num0;
        rem1_next[0] = req.num1;
        den_next[0]  = req.den;
        q0_next[0]   = '0;
        q1_next[0]   = '0;
        side_next[0].lo0    = $signed(req.num0) <= 0;
        side_next[0].hi0    = $signed(req.num0) >= $signed(req.den);
        side_next[0].lo1    = $signed(req.num1) <= 0;
        side_next[0].hi1    = $signed(req.num1) >= $signed(req.den);
        side_next[0].region = req.region;
        side_next[0].geom   = req.geom;

        // remainder stays below den, so the doubled value still fits
        for (int j = 1; j <= cpt_pkg::FRAC_BITS; j++)
        begin
            t0 = {rem0_reg[j-1][cpt_pkg::NUM_W-2:0], 1'b0};
            t1 = {rem1_reg[j-1][cpt_pkg::NUM_W-2:0], 1'b0};
            g0 = t0 >= den_reg[j-1];
            g1 = t1 >= den_reg[j-1];
            rem0_next[j] = g0 ? t0 - den_reg[j-1] : t0;
            rem1_next[j] = g1 ? t1 - den_reg[j-1] : t1;
            den_next[j]  = den_reg[j-1];
            q0_next[j]   = {q0_reg[j-1][cpt_pkg::FRAC_BITS-2:0], g0};
            q1_next[j]   = {q1_reg[j-1][cpt_pkg::FRAC_BITS-2:0], g1};
            side_next[j] = side_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[cpt_pkg::FRAC_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= cpt_pkg::FRAC_BITS; j++)
        begin
            rem0_reg[j] <= rem0_next[j];
            rem1_reg[j] <= rem1_next[j];
            den_reg[j]  <= den_next[j];
            q0_reg[j]   <= q0_next[j];
            q1_reg[j]   <= q1_next[j];
            side_reg[j] <= side_next[j];
        end
    end

    assign side_last = side_reg[cpt_pkg::FRAC_BITS];

    always_comb
    begin
        if (side_last.lo0)
        begin
            wgt0 = '0;
        end
        else if (side_last.hi0)
        begin
            wgt0 = cpt_pkg::WGT_ONE;
        end
        else
        begin
            wgt0 = {1'b0, q0_reg[cpt_pkg::FRAC_BITS]};
        end

        if (side_last.lo1)
        begin
            wgt1 = '0;
        end
        else if (side_last.hi1)
        begin
            wgt1 = cpt_pkg::WGT_ONE;
        end
        else
        begin
            wgt1 = {1'b0, q1_reg[cpt_pkg::FRAC_BITS]};
        end
    end

    assign out_valid = valid_reg[cpt_pkg::FRAC_BITS];
    assign region    = side_last.region;
    assign geom_out  = side_last.geom;

endmodule
`default_nettype wire

/* rtl/cpt_emit.sv */
// Final two stages: weight-times-edge products, then shift, add base and saturate.
// Depends on cpt_pkg.
`default_nettype none
module cpt_emit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [cpt_pkg::WGT_W-1:0] wgt0,
    input  logic [cpt_pkg::WGT_W-1:0] wgt1,
    input  cpt_pkg::region_t          region_in,
    input  cpt_pkg::geom_t            geom_in,
    output logic                      out_valid,
    output cpt_pkg::vec3_t            closest,
    output cpt_pkg::region_t          region_out
);

    logic [1:0] valid_reg;

    logic [2:0][cpt_pkg::EMIT_W-1:0]      ps_reg, pt_reg, ps_next, pt_next;
    cpt_pkg::vec3_t                       base_reg, base_next;
    cpt_pkg::region_t                     region1_reg, region2_reg;
    cpt_pkg::vec3_t                       closest_reg, closest_next;

    always_comb
    begin
        logic signed [cpt_pkg::DIFF_W-1:0] ab, ac, bc, e1;
        for (int k = 0; k < 3; k++)
        begin
            ab = cpt_pkg::DIFF_W'($signed(geom_in.b[k])) - cpt_pkg::DIFF_W'($signed(geom_in.a[k]));
            ac = cpt_pkg::DIFF_W'($signed(geom_in.c[k])) - cpt_pkg::DIFF_W'($signed(geom_in.a[k]));
            bc = cpt_pkg::DIFF_W'($signed(geom_in.c[k])) - cpt_pkg::DIFF_W'($signed(geom_in.b[k]));
            e1 = (region_in == cpt_pkg::REG_E12) ? bc : ab;
            ps_next[k] = cpt_pkg::EMIT_W'($signed({1'b0, wgt0}) * e1);
            pt_next[k] = cpt_pkg::EMIT_W'($signed({1'b0, wgt1}) * ac);
        end

        if (region_in inside {cpt_pkg::REG_V1, cpt_pkg::REG_E12})
        begin
            base_next = geom_in.b;
        end
        else if (region_in == cpt_pkg::REG_V2)
        begin
            base_next = geom_in.c;
        end
        else
        begin
            base_next = geom_in.a;
        end
    end

    always_comb
    begin
        logic signed [cpt_pkg::EMIT_W-1:0] acc, full;
        for (int k = 0; k < 3; k++)
        begin
            acc  = $signed(ps_reg[k]) + $signed(pt_reg[k]);
            acc  = acc >>> cpt_pkg::FRAC_BITS;
            full = acc + cpt_pkg::EMIT_W'($signed(base_reg[k]));
            if (full > cpt_pkg::EMIT_W'(cpt_pkg::COORD_MAX))
            begin
                closest_next[k] = cpt_pkg::COORD_MAX;
            end
            else if (full < cpt_pkg::EMIT_W'(cpt_pkg::COORD_MIN))
            begin
                closest_next[k] = cpt_pkg::COORD_MIN;
            end
            else
            begin
                closest_next[k] = full[cpt_pkg::COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg      <= ps_next;
        pt_reg      <= pt_next;
        base_reg    <= base_next;
        region1_reg <= region_in;
        closest_reg <= closest_next;
        region2_reg <= region1_reg;
    end

    assign out_valid  = valid_reg[1];
    assign closest    = closest_reg;
    assign region_out = region2_reg;

endmodule
`default_nettype wire

/* rtl/closest_point_on_triangle.sv */
// Top level of the closest-point-on-triangle pipeline.
// Depends on cpt_pkg, cpt_dot, cpt_cross, cpt_div and cpt_emit.
//
// Usage
//   Input: a query point and three triangle vertices, signed Q16.16. A
//   transfer happens at a rising edge with start high and busy low. busy
//   is always low: the pipeline takes one query every cycle.
//   Output: closest_x/y/z and region are valid for exactly one cycle while
//   done is high. The receiver cannot hold results off, and since every
//   stage advances every cycle none is ever needed.
//   Ordering: results leave in transfer order, one per cycle at most.
//   Pipeline: 3 stages of differences and dot products, 4 stages of split
//   cross products and region tests, 17 divider stages (an entry stage,
//   then one quotient bit per stage over the 140-bit divisor; FRAC_BITS
//   sets the depth), 2 stages to scale, add and saturate.
//   Region codes: 0 vertex0, 1 vertex1, 2 edge01, 3 vertex2, 4 edge02,
//   5 edge12, 6 interior. A non-positive divisor answers vertex0.
//   Reset: rst_n clears every stage valid bit at once; queries in flight
//   are dropped and no done follows them.
`default_nettype none
module closest_point_on_triangle (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] point_y,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] point_z,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex0_x,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex0_y,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex0_z,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex1_x,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex1_y,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex1_z,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex2_x,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex2_y,
    input  logic signed [cpt_pkg::COORD_WIDTH-1:0] vertex2_z,
    output logic                                  done,
    output logic signed [cpt_pkg::COORD_WIDTH-1:0] closest_x,
    output logic signed [cpt_pkg::COORD_WIDTH-1:0] closest_y,
    output logic signed [cpt_pkg::COORD_WIDTH-1:0] closest_z,
    output logic [2:0]                            region
);

    logic                             xfer;
    cpt_pkg::vec3_t                   point;
    cpt_pkg::geom_t                   geom_in;

    logic                             dot_valid;
    cpt_pkg::dots_t                   dots;
    cpt_pkg::geom_t                   dot_geom;

    logic                             cross_valid;
    cpt_pkg::div_req_t                div_req;

    logic                             div_valid;
    logic [cpt_pkg::WGT_W-1:0]        wgt0, wgt1;
    cpt_pkg::region_t                 div_region;
    cpt_pkg::geom_t                   div_geom;

    cpt_pkg::vec3_t                   closest;
    cpt_pkg::region_t                 region_out;

    // every stage moves each cycle, so a new query is always welcome
    assign busy = 1'b0;
    assign xfer = start && !busy;

    assign point     = {point_z, point_y, point_x};
    assign geom_in.a = {vertex0_z, vertex0_y, vertex0_x};
    assign geom_in.b = {vertex1_z, vertex1_y, vertex1_x};
    assign geom_in.c = {vertex2_z, vertex2_y, vertex2_x};

    cpt_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xfer),
        .point     (point),
        .geom_in   (geom_in),
        .out_valid (dot_valid),
        .dots      (dots),
        .geom_out  (dot_geom)
    );

    cpt_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .dots      (dots),
        .geom_in   (dot_geom),
        .out_valid (cross_valid),
        .req       (div_req)
    );

    cpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .req       (div_req),
        .out_valid (div_valid),
        .wgt0      (wgt0),
        .wgt1      (wgt1),
        .region    (div_region),
        .geom_out  (div_geom)
    );

    cpt_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .wgt0       (wgt0),
        .wgt1       (wgt1),
        .region_in  (div_region),
        .geom_in    (div_geom),
        .out_valid  (done),
        .closest    (closest),
        .region_out (region_out)
    );

    assign closest_x = closest[0];
    assign closest_y = closest[1];
    assign closest_z = closest[2];
    assign region    = region_out;

endmodule
`default_nettype wire

/* rtl/cpt_check.sv */
// Port-level checker for closest_point_on_triangle, bound to the top level.
// Depends on cpt_pkg and closest_point_on_triangle_assert.svh.
`default_nettype none
`include "closest_point_on_triangle_assert.svh"
module cpt_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex0_x,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex0_y,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex0_z,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex1_x,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex1_y,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   vertex1_z,
    input  logic                              done,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   closest_x,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   closest_y,
    input  logic [cpt_pkg::COORD_WIDTH-1:0]   closest_z,
    input  logic [2:0]                        region
);

    // cycles since reset, saturating once history covers a full latency
    logic [cpt_pkg::WARM_W-1:0] warm_reg;
    logic                       warm;

    assign warm = warm_reg == cpt_pkg::WARM_W'(cpt_pkg::LATENCY + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (!warm)
        begin
            warm_reg <= warm_reg + 1'b1;
        end
    end

    `CPT_ASSERT_IMP(a_sched, warm,
        done == $past(start && !busy, cpt_pkg::LATENCY), "done off schedule")
    `CPT_ASSERT_IMP(a_code, done, region <= cpt_pkg::REG_IN, "region code out of range")
    `CPT_ASSERT_IMP(a_v0, warm && done && region == cpt_pkg::REG_V0,
        closest_x == $past(vertex0_x, cpt_pkg::LATENCY)
        && closest_y == $past(vertex0_y, cpt_pkg::LATENCY)
        && closest_z == $past(vertex0_z, cpt_pkg::LATENCY), "vertex0 answer differs")
    `CPT_ASSERT_IMP(a_v1, warm && done && region == cpt_pkg::REG_V1,
        closest_x == $past(vertex1_x, cpt_pkg::LATENCY)
        && closest_y == $past(vertex1_y, cpt_pkg::LATENCY)
        && closest_z == $past(vertex1_z, cpt_pkg::LATENCY), "vertex1 answer differs")

endmodule

bind closest_point_on_triangle cpt_check u_cpt_check (.*);
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for closest_point_on_triangle: a directed table and random queries.
// Checks each result against its typed answer or a wide-integer predictor of the region tests.
// Depends on cpt_pkg and the closest_point_on_triangle RTL.
`timescale 1ns / 1ps
module tb;

    typedef logic signed [31:0]  coord_t;
    typedef logic signed [255:0] wide_t;   // wide enough for every cross term

    typedef struct {
        coord_t p[3];
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
    } query_t;

    typedef struct {
        coord_t     x;
        coord_t     y;
        coord_t     z;
        logic [2:0] rg;
    } nearest_t;

    // Directed row: the query, and a typed answer where it is obvious.
    typedef struct {
        query_t   q;
        bit       typed;
        nearest_t ans;
    } row_t;

    localparam coord_t ONE   = 32'sd65536;
    localparam coord_t HALF  = 32'sd32768;
    localparam coord_t QUART = 32'sd16384;
    localparam coord_t CMAX  = cpt_pkg::COORD_MAX;
    localparam coord_t CMIN  = cpt_pkg::COORD_MIN;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    coord_t     point_x, point_y, point_z;
    coord_t     vertex0_x, vertex0_y, vertex0_z;
    coord_t     vertex1_x, vertex1_y, vertex1_z;
    coord_t     vertex2_x, vertex2_y, vertex2_z;
    logic       done;
    coord_t     closest_x, closest_y, closest_z;
    logic [2:0] region;

    nearest_t pending_q[$];
    int       mismatches;
    int       failures;
    row_t     rows[$];

    closest_point_on_triangle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .vertex0_x (vertex0_x),
        .vertex0_y (vertex0_y),
        .vertex0_z (vertex0_z),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex1_z (vertex1_z),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .vertex2_z (vertex2_z),
        .done      (done),
        .closest_x (closest_x),
        .closest_y (closest_y),
        .closest_z (closest_z),
        .region    (region)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: exact dot products and cross terms, weights floored
    // to FRAC_BITS, coordinates saturated to 32 bits.
    // ---------------------------------------------------------------
    function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // floor(num * 2^F / den), clamped to [0, 1.0]; den > 0
    function automatic wide_t bary_weight(input wide_t num, input wide_t den);
        if (num <= 0)
            return 0;
        if (num >= den)
            return wide_t'(1) <<< cpt_pkg::FRAC_BITS;
        return (num <<< cpt_pkg::FRAC_BITS) / den;
    endfunction

    function automatic nearest_t place_point(input wide_t base[3], input wide_t s,
                                             input wide_t e1[3], input wide_t t,
                                             input wide_t e2[3], input logic [2:0] rg);
        nearest_t r;
        wide_t    acc;
        coord_t   o[3];
        for (int k = 0; k < 3; k++)
        begin
            acc = base[k] + ((s * e1[k] + t * e2[k]) >>> cpt_pkg::FRAC_BITS);
            if (acc < wide_t'(CMIN))
                acc = wide_t'(CMIN);
            if (acc > wide_t'(CMAX))
                acc = wide_t'(CMAX);
            o[k] = acc[31:0];
        end
        r.x  = o[0];
        r.y  = o[1];
        r.z  = o[2];
        r.rg = rg;
        return r;
    endfunction

    function automatic nearest_t nearest_on_triangle(input query_t q);
        wide_t    p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        wide_t    d1, d2, d3, d4, d5, d6, va, vb, vc, den, e1, e2;
        nearest_t at_a;
        for (int k = 0; k < 3; k++)
        begin
            p[k]  = wide_t'(q.p[k]);
            a[k]  = wide_t'(q.a[k]);
            b[k]  = wide_t'(q.b[k]);
            c[k]  = wide_t'(q.c[k]);
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            bc[k] = c[k] - b[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        at_a = place_point(a, 0, ab, 0, ac, cpt_pkg::REG_V0);

        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        if (d1 <= 0 && d2 <= 0)
            return at_a;

        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        if (d3 >= 0 && d4 <= d3)
            return place_point(b, 0, ab, 0, ac, cpt_pkg::REG_V1);

        vc = d1 * d4 - d3 * d2;
        if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            den = d1 - d3;
            if (den <= 0)
                return at_a;
            return place_point(a, bary_weight(d1, den), ab, 0, ac, cpt_pkg::REG_E01);
        end

        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        if (d6 >= 0 && d5 <= d6)
            return place_point(c, 0, ab, 0, ac, cpt_pkg::REG_V2);

        vb = d5 * d2 - d1 * d6;
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            den = d2 - d6;
            if (den <= 0)
                return at_a;
            return place_point(a, 0, ab, bary_weight(d2, den), ac, cpt_pkg::REG_E02);
        end

        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            den = e1 + e2;
            if (den <= 0)
                return at_a;
            return place_point(b, bary_weight(e1, den), bc, 0, ac, cpt_pkg::REG_E12);
        end

        den = va + vb + vc;
        if (den <= 0)
            return at_a;
        return place_point(a, bary_weight(vb, den), ab, bary_weight(vc, den), ac,
                           cpt_pkg::REG_IN);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic query_t mk_query(input coord_t px, py, pz, ax, ay, az,
                                        input coord_t bx, by, bz, cx, cy, cz);
        query_t q;
        q.p = '{px, py, pz};
        q.a = '{ax, ay, az};
        q.b = '{bx, by, bz};
        q.c = '{cx, cy, cz};
        return q;
    endfunction

    function automatic nearest_t mk_ans(input coord_t x, y, z, input logic [2:0] rg);
        nearest_t r;
        r.x  = x;
        r.y  = y;
        r.z  = z;
        r.rg = rg;
        return r;
    endfunction

    task automatic add_row(input query_t q, input bit typed, input nearest_t ans);
        row_t r;
        r.q     = q;
        r.typed = typed;
        r.ans   = ans;
        rows.push_back(r);
    endtask

    // Random coordinate: mostly moderate, sometimes any 32-bit value.
    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0:       return $signed($urandom);
            1:       return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
            default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     mode;
        int     sel;
        sel  = $urandom_range(0, 99);
        mode = (sel < 20) ? 0 : (sel < 70) ? 1 : 2;
        for (int k = 0; k < 3; k++)
        begin
            q.p[k] = rand_coord(mode);
            q.a[k] = rand_coord(mode);
            q.b[k] = rand_coord(mode);
            q.c[k] = rand_coord(mode);
        end
        // occasionally a degenerate triangle: repeated vertex
        if ($urandom_range(0, 19) == 0)
            q.c = q.a;
        return q;
    endfunction

    // Hold the query on the ports until the transfer edge.
    task automatic send_query(input query_t q, input bit typed, input nearest_t ans);
        point_x   <= q.p[0];
        point_y   <= q.p[1];
        point_z   <= q.p[2];
        vertex0_x <= q.a[0];
        vertex0_y <= q.a[1];
        vertex0_z <= q.a[2];
        vertex1_x <= q.b[0];
        vertex1_y <= q.b[1];
        vertex1_z <= q.b[2];
        vertex2_x <= q.c[0];
        vertex2_y <= q.c[1];
        vertex2_z <= q.c[2];
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_q.push_back(typed ? ans : nearest_on_triangle(q));
    endtask

    // Sender gap, about 26 in a hundred, none during the quiet stretch.
    task automatic maybe_idle(input int idx);
        if ((idx < 300 || idx > 550) && $urandom_range(0, 99) < 26)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking: done is a one-cycle strobe, no back-pressure.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result: %0d %0d %0d region %0d",
                             closest_x, closest_y, closest_z, region);
                mismatches++;
            end
            else if (closest_x !== pending_q[0].x || closest_y !== pending_q[0].y ||
                     closest_z !== pending_q[0].z || region !== pending_q[0].rg)
            begin
                failures++;
                if (mismatches < 10)
                    $display({"mismatch: expected %0d %0d %0d region %0d, ",
                              "got %0d %0d %0d region %0d"},
                             pending_q[0].x, pending_q[0].y, pending_q[0].z, pending_q[0].rg,
                             closest_x, closest_y, closest_z, region);
                mismatches++;
                void'(pending_q.pop_front());
            end
            else
                void'(pending_q.pop_front());
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        nearest_t none;
        query_t   q;
        none       = mk_ans(0, 0, 0, cpt_pkg::REG_V0);
        mismatches = 0;
        failures   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        {point_x, point_y, point_z}       = '0;
        {vertex0_x, vertex0_y, vertex0_z} = '0;
        {vertex1_x, vertex1_y, vertex1_z} = '0;
        {vertex2_x, vertex2_y, vertex2_z} = '0;

        // unit right triangle A=0, B=x, C=y: at least one row per region
        add_row(mk_query(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1,
                mk_ans(0, 0, 0, cpt_pkg::REG_V0));
        add_row(mk_query(2 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1,
                mk_ans(ONE, 0, 0, cpt_pkg::REG_V1));
        add_row(mk_query(0, 2 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1,
                mk_ans(0, ONE, 0, cpt_pkg::REG_V2));
        add_row(mk_query(HALF, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, none);
        add_row(mk_query(-ONE, HALF, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, none);
        add_row(mk_query(ONE, ONE, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, none);
        add_row(mk_query(QUART, QUART, 5 * ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, none);
        add_row(mk_query(ONE / 3, ONE / 7, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, none);
        // degenerate triangles: all zero, all at one extreme, collinear, repeated
        add_row(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
        add_row(mk_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                         CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
                mk_ans(CMAX, CMAX, CMAX, cpt_pkg::REG_V0));
        add_row(mk_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                         CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1,
                mk_ans(CMIN, CMIN, CMIN, cpt_pkg::REG_V0));
        add_row(mk_query(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0), 0, none);
        add_row(mk_query(HALF, ONE, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0), 0, none);
        add_row(mk_query(ONE, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 0, none);
        // full-scale triangles: largest products and saturation
        add_row(mk_query(CMAX, CMIN, CMAX, CMIN, CMIN, CMIN,
                         CMAX, CMIN, CMIN, CMIN, CMAX, CMIN), 0, none);
        add_row(mk_query(0, 0, CMIN, CMIN, CMIN, CMAX,
                         CMAX, CMIN, CMAX, CMIN, CMAX, CMAX), 0, none);
        add_row(mk_query(CMIN, CMAX, 0, CMAX, CMIN, 0,
                         CMAX, CMAX, 0, CMIN, CMIN, 0), 0, none);
        add_row(mk_query(-1, -1, -1, CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX), 0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < rows.size(); i++)
        begin
            send_query(rows[i].q, rows[i].typed, rows[i].ans);
            maybe_idle(i);
        end

        for (int i = 0; i < 900; i++)
        begin
            q = rand_query();
            send_query(q, 0, none);
            if (i == 450)
            begin
                // drain the pipeline once before going on
                start <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_idle(i);
        end
        start <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (cpt_pkg::LATENCY + 10) @(posedge clk);

        if (failures == 0)
            $display("[closest_point_on_triangle] OK");
        else
            $display("[closest_point_on_triangle] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #200000;
        $display("[closest_point_on_triangle] ERROR");
        $finish;
    end

endmodule

/* closest_point_on_triangle.f */
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_dot.sv
rtl/cpt_cross.sv
rtl/cpt_div.sv
rtl/cpt_emit.sv
rtl/closest_point_on_triangle.sv
rtl/cpt_check.sv
test/tb.sv
